[design/sfp_pkg.sv]
// Shared types, constants and the CRC-8 step for the sample frame packer.
// No dependencies; imported by sfp_emitter and sample_frame_packer_crc8.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int SAMPLES_PER_FRAME_DEFAULT = 10;
  localparam logic [8:0] FRAMES_PER_CAPTURE_RESET = 9'd100;
  localparam logic [7:0] CRC_POLY = 8'h8D;
  localparam int ITEM_BYTES = 3;

  // Up to three bytes caused by one sample; an eof slot is filled with the CRC on the way out.
  typedef struct packed {
    logic [ITEM_BYTES-1:0][7:0] data;
    logic [ITEM_BYTES-1:0]      eof;
    logic [1:0]                 count;
  } sfp_item_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[design/sample_frame_packer_crc8.sv]
// Top level of the sample frame packer: slot tracking, byte packing, frame index.
// Depends on sfp_pkg and sfp_emitter.
`timescale 1ns / 1ps

// Usage:
//   Samples enter on sample / sample_valid / sample_stall; a transaction takes
//   place at a clock edge with valid high and stall low. Frame bytes leave on
//   frame_byte / end_of_frame / last_of_run with byte_valid / byte_stall.
//   Each sample yields 1 to 3 bytes: header, index and high byte in slot 0;
//   one byte in other even slots; two in odd and last slots; last adds the CRC.
//   Bytes leave one per cycle, unless byte_stall holds them, from a single
//   output register, so a sample occupies the block until all its bytes
//   have moved out; the next sample is taken in the cycle its predecessor's
//   last byte moves out. A sample's bytes enter the emitter buffer at its
//   transaction, then become valid in the output register, barring a stall.
//   cfg_we writes frames_per_capture (reset 100) from cfg_wdata; write it only
//   while idle.
//   Reset (rst, synchronous) clears the slot, index, CRC and output valid.
//   A stall on the byte side holds the output byte; the buffer behind it
//   fills and sample_stall rises until bytes move again.

module sample_frame_packer_crc8
  import sfp_pkg::*;
#(
  parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic [11:0] sample,
  input  logic        sample_valid,
  output logic        sample_stall,
  output logic [7:0]  frame_byte,
  output logic        end_of_frame,
  output logic        last_of_run,
  output logic        byte_valid,
  input  logic        byte_stall
);

  localparam int POS_W = $clog2(SAMPLES_PER_FRAME);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES_PER_FRAME - 1);
  localparam logic [7:0] HEADER = 8'(SAMPLES_PER_FRAME);

  logic [8:0]       frames_per_capture;
  logic [POS_W-1:0] sample_position;
  logic [3:0]       held_low_nibble;
  logic [7:0]       frame_index;
  logic [8:0]       index_inc;
  logic             item_ready;
  logic             accept;
  logic             last;
  sfp_item_t        item;

  assign sample_stall = !item_ready;
  assign accept       = sample_valid && item_ready;
  assign last         = (sample_position == LAST_POS);
  assign index_inc    = {1'b0, frame_index} + 9'd1;

  always_comb begin
    item = '0;
    if (sample_position == '0) begin
      item.data  = {sample[11:4], frame_index, HEADER};
      item.count = 2'd3;
    end else if (!sample_position[0]) begin
      item.data[0] = sample[11:4];
      if (last) begin
        item.data[1] = {sample[3:0], 4'h0};
        item.eof[2]  = 1'b1;
        item.count   = 2'd3;
      end else begin
        item.count = 2'd1;
      end
    end else begin
      item.data[0] = {held_low_nibble, sample[11:8]};
      item.data[1] = sample[7:0];
      if (last) begin
        item.eof[2] = 1'b1;
        item.count  = 2'd3;
      end else begin
        item.count = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_capture <= FRAMES_PER_CAPTURE_RESET;
      sample_position    <= '0;
      held_low_nibble    <= 4'h0;
      frame_index        <= 8'h00;
    end else begin
      if (cfg_we) begin
        frames_per_capture <= cfg_wdata;
      end
      if (accept) begin
        if (!sample_position[0]) begin
          held_low_nibble <= sample[3:0];
        end
        if (last) begin
          sample_position <= '0;
          frame_index     <= (index_inc >= frames_per_capture) ? 8'h00 : index_inc[7:0];
        end else begin
          sample_position <= sample_position + POS_W'(1);
        end
      end
    end
  end

  sfp_emitter u_emitter (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (sample_valid),
    .item         (item),
    .item_ready   (item_ready),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .frame_byte   (frame_byte),
    .end_of_frame (end_of_frame),
    .last_of_run  (last_of_run)
  );

  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    sample_position <= LAST_POS)
    else $error("slot beyond frame");

  a_wrap : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> sample_position == '0)
    else $error("slot did not wrap at frame end");

  a_index_hold : assert property (@(posedge clk) disable iff (rst)
    !(accept && last) |=> frame_index == $past(frame_index))
    else $error("frame index moved mid-frame");

endmodule

[design/sfp_emitter.sv]
// Byte emitter: holds a sample's bytes, sends one per unstalled cycle, runs frame CRC.
// Depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_emitter
  import sfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  sfp_item_t  item,
  output logic       item_ready,
  output logic       byte_valid,
  input  logic       byte_stall,
  output logic [7:0] frame_byte,
  output logic       end_of_frame,
  output logic       last_of_run
);

  logic [ITEM_BYTES-1:0][7:0] buf_data;
  logic [ITEM_BYTES-1:0]      buf_eof;
  logic [1:0]                 buf_cnt;
  logic [7:0]                 crc;
  logic                       move;
  logic                       load;

  assign move       = (buf_cnt != 2'd0) && (!byte_valid || !byte_stall);
  assign item_ready = (buf_cnt == 2'd0) || ((buf_cnt == 2'd1) && move);
  assign load       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt    <= 2'd0;
      byte_valid <= 1'b0;
      crc        <= 8'h00;
    end else begin
      if (load) begin
        buf_cnt <= item.count;
      end else if (move) begin
        buf_cnt <= buf_cnt - 2'd1;
      end
      if (move) begin
        byte_valid <= 1'b1;
        crc        <= buf_eof[0] ? 8'h00 : crc8_update(crc, buf_data[0]);
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_data <= item.data;
      buf_eof  <= item.eof;
    end else if (move) begin
      buf_data <= {8'h00, buf_data[ITEM_BYTES-1:1]};
      buf_eof  <= {1'b0, buf_eof[ITEM_BYTES-1:1]};
    end
    if (move) begin
      frame_byte   <= buf_eof[0] ? crc : buf_data[0];
      end_of_frame <= buf_eof[0];
      last_of_run  <= (buf_cnt == 2'd1);
    end
  end

  a_load_fills : assert property (@(posedge clk) disable iff (rst)
    load |=> buf_cnt != 2'd0)
    else $error("accepted item left the buffer empty");

  a_eof_is_last : assert property (@(posedge clk) disable iff (rst)
    byte_valid && end_of_frame |-> last_of_run)
    else $error("CRC byte not marked last of run");

  a_crc_cleared : assert property (@(posedge clk) disable iff (rst)
    move && buf_eof[0] |=> crc == 8'h00)
    else $error("CRC not cleared after frame end");

  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    buf_cnt >= 2'd2 |-> !item_ready)
    else $error("ready with more than one byte pending");

endmodule
